@@ hw/rtl/multichannel_lag_smoother_assert.svh @@
// Assertion macros for the lag smoother checker
`ifndef MULTICHANNEL_LAG_SMOOTHER_ASSERT_SVH
`define MULTICHANNEL_LAG_SMOOTHER_ASSERT_SVH

// checked property, disabled while reset is low
`define MLS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lag smoother assertion failed");

// checked property, also active during reset
`define MLS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lag smoother assertion failed");

`endif

@@ hw/rtl/mls_pkg.sv @@
// Shared types, constants and tables of the lag smoother
`timescale 1ns / 1ps
package mls_pkg;

  localparam int Channels = 16;
  localparam int ChW      = 4;
  localparam int SampleW  = 24;
  localparam int LagW     = 16;
  localparam int RateW    = 18;
  localparam int DW       = LagW + RateW;  // lag times rate
  localparam int NumW     = 43;            // dividend and quotient
  localparam int QDepth   = 2;
  localparam int AddrW    = 3;

  localparam logic [NumW-1:0] KQ24 = 43'd2675169848851;  // 16000*log2(1000) in Q24
  localparam logic [RateW-1:0] RateReset = 18'd48000;
  localparam logic [AddrW-1:0] RegRateAddr = 3'd0;
  localparam logic [23:0] AMax = 24'hFFFFFF;

  typedef struct packed {
    logic               rst;   // reset request word
    logic               dzero; // lag times rate is zero
    logic [ChW-1:0]     ch;
    logic [SampleW-1:0] x;
    logic [DW-1:0]      d;
  } item_t;

  // 2^(-k/16) in Q24
  function automatic logic [24:0] exp2_tab(input logic [4:0] k);
    logic [24:0] v;
    case (k)
      5'd0:    v = 25'd16777216;
      5'd1:    v = 25'd16065917;
      5'd2:    v = 25'd15384775;
      5'd3:    v = 25'd14732511;
      5'd4:    v = 25'd14107901;
      5'd5:    v = 25'd13509772;
      5'd6:    v = 25'd12937002;
      5'd7:    v = 25'd12388516;
      5'd8:    v = 25'd11863283;
      5'd9:    v = 25'd11360319;
      5'd10:   v = 25'd10878679;
      5'd11:   v = 25'd10417458;
      5'd12:   v = 25'd9975792;
      5'd13:   v = 25'd9552851;
      5'd14:   v = 25'd9147842;
      5'd15:   v = 25'd8760003;
      5'd16:   v = 25'd8388608;
      default: v = 25'd8388608;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/mls_front.sv @@
// Front end: accepts words, drops bad channels, forms lag times rate
`timescale 1ns / 1ps
module mls_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [mls_pkg::ChW-1:0]     channel_i,
  input  logic [mls_pkg::SampleW-1:0] sample_i,
  input  logic [mls_pkg::LagW-1:0]    lag_i,
  input  logic [mls_pkg::RateW-1:0]   rate_i,
  output logic                        push_o,
  input  logic                        push_ready_i,
  output mls_pkg::item_t              item_o
);

  logic           valid_q, valid_d;
  mls_pkg::item_t item_q, item_d;
  logic           take, keep;
  logic [mls_pkg::DW-1:0] d;

  assign push_o     = valid_q;
  assign item_o     = item_q;
  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  // reset words always go on; samples only for channels that exist
  assign keep = opcode_i ||
                ({1'b0, channel_i} < (mls_pkg::ChW + 1)'(mls_pkg::Channels));
  assign d    = mls_pkg::DW'(lag_i) * mls_pkg::DW'(rate_i);

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (valid_q && push_ready_i) valid_d = 1'b0;
    if (take) begin
      valid_d      = keep;
      item_d.rst   = opcode_i;
      item_d.ch    = channel_i;
      item_d.x     = sample_i;
      item_d.d     = d;
      item_d.dzero = (d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ hw/rtl/mls_queue.sv @@
// Short FIFO between front and back end
`timescale 1ns / 1ps
module mls_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  mls_pkg::item_t item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output mls_pkg::item_t item_o
);

  localparam int PtrW = (mls_pkg::QDepth > 1) ? $clog2(mls_pkg::QDepth) : 1;
  localparam int CntW = $clog2(mls_pkg::QDepth + 1);

  mls_pkg::item_t mem_q [mls_pkg::QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(mls_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(mls_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = do_push ? inc(wr_q) : wr_q;
    rd_d  = do_pop ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

@@ hw/rtl/mls_back.sv @@
// Back end: coefficient divider, 2^-x interpolation, filter update, output register
`timescale 1ns / 1ps
module mls_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_o,
  input  mls_pkg::item_t              item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mls_pkg::ChW-1:0]     channel_o,
  output logic [mls_pkg::SampleW-1:0] sample_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV    = 7'b0000010,
    ST_INTERP = 7'b0000100,
    ST_SCALE  = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_ADD    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  localparam int NumW = mls_pkg::NumW;
  localparam int DW   = mls_pkg::DW;
  localparam int CntW = $clog2(NumW);

  state_e state_q, state_d;
  logic [mls_pkg::Channels-1:0] snap_q, snap_d;
  logic [31:0] last_q [mls_pkg::Channels];
  logic [mls_pkg::ChW-1:0] ch_q, ch_d;
  logic [31:0] xs_q, xs_d;      // sample in Q1.31
  logic [DW-1:0] d_q, d_d;
  logic [NumW-1:0] num_q, num_d; // dividend, becomes quotient
  logic [DW:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [18:0] ip_q, ip_d;
  logic [24:0] t0_q, t0_d;
  logic [39:0] prod_q, prod_d;
  logic [23:0] a_q, a_d;
  logic signed [32:0] diff_q, diff_d;
  logic signed [57:0] mul_q, mul_d;
  logic [31:0] y_q, y_d;
  logic out_valid_q, out_valid_d;
  logic [mls_pkg::ChW-1:0] och_q;
  logic [mls_pkg::SampleW-1:0] osample_q;
  logic write_out;

  // divider step
  logic [DW:0] sh;
  logic ge;
  // interpolation
  logic [4:0] idx;
  logic [24:0] t1;
  logic [19:0] tdiff;
  // scale
  logic [24:0] m, half, a_full;
  logic [4:0] sft;
  // rounding
  logic [57:0] mag;
  logic [33:0] rs;
  logic signed [33:0] y_full;
  logic [32:0] ymag, omag;
  logic signed [33:0] o_full;
  logic [mls_pkg::SampleW-1:0] o_sat;

  assign sh    = {rem_q[DW-1:0], num_q[NumW-1]};
  assign ge    = (sh >= {1'b0, d_q});
  assign idx   = {1'b0, num_q[23:20]};
  assign t1    = mls_pkg::exp2_tab(idx + 5'd1);
  assign tdiff = 20'(mls_pkg::exp2_tab(idx) - t1);
  assign m     = t0_q - 25'((41'(prod_q) + 41'd524288) >> 20);
  assign sft   = ip_q[4:0];
  assign half  = (sft == '0) ? '0 : (25'd1 << (sft - 5'd1));
  assign a_full = (m + half) >> sft;

  // half away from zero, by 2^24
  assign mag = mul_q[57] ? 58'(-mul_q) : 58'(mul_q);
  assign rs  = 34'((mag + 58'd8388608) >> 24);
  assign y_full = $signed({{2{xs_q[31]}}, xs_q}) +
                  (mul_q[57] ? -$signed(rs) : $signed(rs));

  // output rounding by 2^8 and saturation
  assign ymag   = y_q[31] ? 33'(-$signed({y_q[31], y_q})) : {1'b0, y_q};
  assign omag   = (ymag + 33'd128) >> 8;
  assign o_full = y_q[31] ? -$signed({1'b0, omag}) : $signed({1'b0, omag});
  assign o_sat  = (o_full > 34'sd8388607)  ? 24'h7FFFFF :
                  (o_full < -34'sd8388608) ? 24'h800000 : o_full[23:0];

  assign pop_o       = (state_q == ST_IDLE);
  assign write_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign channel_o   = och_q;
  assign sample_o    = osample_q;

  always_comb begin
    state_d = state_q;
    snap_d  = snap_q;
    ch_d    = ch_q;
    xs_d    = xs_q;
    d_d     = d_q;
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    ip_d    = ip_q;
    t0_d    = t0_q;
    prod_d  = prod_q;
    a_d     = a_q;
    diff_d  = diff_q;
    mul_d   = mul_q;
    y_d     = y_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          if (item_i.rst) begin
            snap_d = '1;
          end else begin
            ch_d  = item_i.ch;
            xs_d  = {item_i.x, 8'd0};
            d_d   = item_i.d;
            num_d = mls_pkg::KQ24 + NumW'(item_i.d >> 1);
            rem_d = '0;
            cnt_d = '0;
            if (snap_q[item_i.ch] || item_i.dzero) begin
              y_d     = {item_i.x, 8'd0};
              state_d = ST_DONE;
            end else begin
              state_d = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        rem_d = ge ? (sh - {1'b0, d_q}) : sh;
        num_d = {num_q[NumW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) state_d = ST_INTERP;
      end
      ST_INTERP: begin
        ip_d    = num_q[NumW-1:24];
        t0_d    = mls_pkg::exp2_tab(idx);
        prod_d  = 40'(tdiff) * 40'(num_q[19:0]);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (ip_q > 19'd24) a_d = '0;
        else if (a_full > 25'(mls_pkg::AMax)) a_d = mls_pkg::AMax;
        else a_d = a_full[23:0];
        diff_d  = $signed({last_q[ch_q][31], last_q[ch_q]}) - $signed({xs_q[31], xs_q});
        state_d = ST_MUL;
      end
      ST_MUL: begin
        mul_d   = $signed({34'd0, a_q}) * 58'(diff_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        y_d     = y_full[31:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (write_out) begin
          out_valid_d  = 1'b1;
          snap_d[ch_q] = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      snap_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mls_pkg::Channels; i++) last_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      snap_q      <= snap_d;
      out_valid_q <= out_valid_d;
      if (write_out) last_q[ch_q] <= y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    xs_q   <= xs_d;
    d_q    <= d_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    ip_q   <= ip_d;
    t0_q   <= t0_d;
    prod_q <= prod_d;
    a_q    <= a_d;
    diff_q <= diff_d;
    mul_q  <= mul_d;
    y_q    <= y_d;
    if (write_out) begin
      och_q     <= ch_q;
      osample_q <= o_sat;
    end
  end

endmodule

@@ hw/rtl/multichannel_lag_smoother.sv @@
// The back end takes one word at a time from the queue and finishes it before the next;
// a filtered word runs through the 43-step divider, interpolation, scale, multiply and add,
// pass-through words go straight to the output register, and reset words only set the marks.
// The front end and 2-word queue keep accepting while the back end works, until both are full.
// Reset: asynchronous, active low; clears channel state, marks, queue and rate (48000).
`timescale 1ns / 1ps
module multichannel_lag_smoother (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [47:0]                 s_axis_tdata_i,  // channel, sample_in, lag_time, zero pad
  input  logic [0:0]                  s_axis_tuser_i,  // opcode
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [31:0]                 m_axis_tdata_o,  // channel_out, sample_out, zero pad
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [mls_pkg::AddrW-1:0]   paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);

  logic [mls_pkg::RateW-1:0] rate_q;
  logic           push, push_ready, pop_valid, pop;
  mls_pkg::item_t push_item, pop_item;
  logic [mls_pkg::ChW-1:0]     ch_out;
  logic [mls_pkg::SampleW-1:0] smp_out;
  logic sel_rate;

  assign pready_o = 1'b1;
  assign sel_rate = (paddr_i[mls_pkg::AddrW-1] == mls_pkg::RegRateAddr[mls_pkg::AddrW-1]);
  assign prdata_o = sel_rate ? 32'(rate_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= mls_pkg::RateReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o && sel_rate) begin
      rate_q <= pwdata_i[mls_pkg::RateW-1:0];
    end
  end

  mls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i[0]),
    .channel_i   (s_axis_tdata_i[3:0]),
    .sample_i    (s_axis_tdata_i[27:4]),
    .lag_i       (s_axis_tdata_i[43:28]),
    .rate_i      (rate_q),
    .push_o      (push),
    .push_ready_i(push_ready),
    .item_o      (push_item)
  );

  mls_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .item_i      (push_item),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .item_o      (pop_item)
  );

  mls_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_o      (pop),
    .item_i     (pop_item),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .channel_o  (ch_out),
    .sample_o   (smp_out)
  );

  assign m_axis_tdata_o = {4'd0, smp_out, ch_out};

endmodule

@@ hw/rtl/mls_checker.sv @@
// Port-level checker for the lag smoother, bound to the top level
`timescale 1ns / 1ps
`include "multichannel_lag_smoother_assert.svh"
module mls_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [31:0]               m_axis_tdata_o,
  input logic                      psel_i,
  input logic                      penable_i,
  input logic                      pwrite_i,
  input logic [mls_pkg::AddrW-1:0] paddr_i,
  input logic [31:0]               pwdata_i,
  input logic [31:0]               prdata_o,
  input logic                      pready_o
);

  // a stalled result word stays offered
  `MLS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // no result in the cycle after a reset cycle
  `MLS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

  // rate register reads back what was written
  `MLS_ASSERT(a_rate_readback, clk_i, rst_ni, psel_i && penable_i && pwrite_i && pready_o && paddr_i[2] == 1'b0 |=> paddr_i[2] != 1'b0 || prdata_o[17:0] == $past(pwdata_i[17:0]))

endmodule

bind multichannel_lag_smoother mls_checker u_mls_checker (.*);
